// ===== hdl/sacrr_pkg.sv =====
`default_nettype none
package sacrr_pkg;

  // Cache geometry
  localparam int LineBytes = 64;
  localparam int LineCount = 256;
  localparam int AddrBits  = 32;

  localparam int OffBits  = $clog2(LineBytes);
  localparam int LineBits = $clog2(LineCount);
  localparam int TagW     = AddrBits - OffBits;

  // Tag store banking: a row holds Lanes consecutive lines
  localparam int Lanes    = 4;
  localparam int LaneBits = $clog2(Lanes);
  localparam int RowBits  = LineBits - LaneBits;
  localparam int Rows     = LineCount / Lanes;

  // Field and register widths
  localparam int WaysLog2W = 4;
  localparam int SeedW     = 16;
  localparam int WayW      = 8;
  localparam int CountW    = 32;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgWaysLog2   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRandomSeed = 2'd1;

  localparam logic [SeedW-1:0] SeedDefault = 16'hACE1;
  localparam logic [SeedW-1:0] LfsrTaps    = 16'hB400;

  typedef struct packed {
    logic [TagW-1:0]      tag;
    logic [LineBits-1:0]  base;
    logic [WaysLog2W-1:0] wlog;
  } req_t;

  typedef struct packed {
    logic             clr_valid;
    logic             seed_load;
    logic [SeedW-1:0] seed;
  } cfg_cmd_t;

  function automatic logic [SeedW-1:0] lfsr_next(input logic [SeedW-1:0] s);
    logic [SeedW-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LfsrTaps;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sacrr_front.sv =====
`default_nettype none
module sacrr_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [sacrr_pkg::AddrBits-1:0]      address_i,
  input  wire logic [sacrr_pkg::WaysLog2W-1:0]     ways_log2_i,
  output      logic                                req_valid_o,
  output      sacrr_pkg::req_t                     req_o,
  input  wire logic                                req_pop_i
);

  logic [sacrr_pkg::WaysLog2W-1:0] wlog;
  logic [sacrr_pkg::WaysLog2W-1:0] set_bits;
  logic [sacrr_pkg::TagW-1:0]      block;
  sacrr_pkg::req_t                 req_new;

  sacrr_pkg::req_t                 queue_q [sacrr_pkg::QueueDepth];
  logic [sacrr_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sacrr_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sacrr_pkg::QCntW-1:0]     count_q, count_d;
  logic                            push;

  // Split the address: clamp associativity, then set index and tag
  always_comb begin
    if (ways_log2_i > sacrr_pkg::WaysLog2W'(sacrr_pkg::LineBits)) begin
      wlog = sacrr_pkg::WaysLog2W'(sacrr_pkg::LineBits);
    end else begin
      wlog = ways_log2_i;
    end
    set_bits     = sacrr_pkg::WaysLog2W'(sacrr_pkg::LineBits) - wlog;
    block        = address_i[sacrr_pkg::AddrBits-1:sacrr_pkg::OffBits];
    req_new.tag  = block >> set_bits;
    req_new.base = block[sacrr_pkg::LineBits-1:0] << wlog;
    req_new.wlog = wlog;
  end

  assign in_ready_o  = (count_q != sacrr_pkg::QCntW'(sacrr_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign req_valid_o = (count_q != '0);
  assign req_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (req_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !req_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && req_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= req_new;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_i |-> count_q != '0)
    else $error("queue popped while empty");

  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !req_pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sacrr_pkg::QCntW'(sacrr_pkg::QueueDepth))
    else $error("queue count overflow");

endmodule
`default_nettype wire

// ===== hdl/sacrr_back.sv =====
`default_nettype none
module sacrr_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sacrr_pkg::cfg_cmd_t               cfg_cmd_i,
  input  wire logic                              req_valid_i,
  input  wire sacrr_pkg::req_t                   req_i,
  output      logic                              req_pop_o,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic                              hit_o,
  output      logic [sacrr_pkg::WayW-1:0]        way_o,
  output      logic                              replaced_valid_o,
  output      logic [sacrr_pkg::CountW-1:0]      hit_total_o,
  output      logic [sacrr_pkg::CountW-1:0]      miss_total_o
);

  typedef enum logic [1:0] {StIdle, StScan, StFinish} state_e;

  localparam int LB = sacrr_pkg::LineBits;
  localparam int RB = sacrr_pkg::RowBits;

  state_e                         state_q, state_d;
  logic [sacrr_pkg::TagW-1:0]     tag_q, tag_d;
  logic [LB-1:0]                  base_q, base_d;
  logic [sacrr_pkg::WaysLog2W-1:0] wlog_q, wlog_d;
  logic [RB-1:0]                  row_q, row_d;
  logic [RB-1:0]                  last_row_q, last_row_d;
  logic                           hit_q, hit_d;
  logic                           found_q, found_d;
  logic [LB-1:0]                  way_q, way_d;
  logic [sacrr_pkg::SeedW-1:0]    lfsr_q, lfsr_d;
  logic [sacrr_pkg::CountW-1:0]   hit_cnt_q, hit_cnt_d;
  logic [sacrr_pkg::CountW-1:0]   miss_cnt_q, miss_cnt_d;
  logic [sacrr_pkg::LineCount-1:0] valid_q, valid_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_hit_q, out_hit_d;
  logic [sacrr_pkg::WayW-1:0]     out_way_q, out_way_d;
  logic                           out_repl_q, out_repl_d;

  logic [sacrr_pkg::TagW-1:0]     tag_mem [sacrr_pkg::Lanes][sacrr_pkg::Rows];
  logic [sacrr_pkg::TagW-1:0]     rd_tags [sacrr_pkg::Lanes];

  logic [LB-1:0]                  way_mask;
  logic [RB-1:0]                  row_span;
  logic [RB:0]                    span_pow;
  logic                           any_match, any_inval;
  logic [LB-1:0]                  match_way, inval_way;
  logic [sacrr_pkg::SeedW-1:0]    lfsr_nxt;
  logic                           out_load;
  logic                           fill_we;
  logic [LB-1:0]                  fill_way, fill_line;

  assign way_mask = LB'(((LB+1)'(1) << wlog_q) - 1'b1);
  assign lfsr_nxt = sacrr_pkg::lfsr_next(lfsr_q);

  // Rows spanned by the incoming request's set, minus one
  always_comb begin
    span_pow = '0;
    row_span = '0;
    if (req_i.wlog > sacrr_pkg::WaysLog2W'(sacrr_pkg::LaneBits)) begin
      span_pow = (RB+1)'(1) << (req_i.wlog - sacrr_pkg::WaysLog2W'(sacrr_pkg::LaneBits));
      row_span = RB'(span_pow - 1'b1);
    end
  end

  // Compare one row of tags; lowest lane wins
  always_comb begin
    logic [LB-1:0] lane_line;
    logic [LB-1:0] lane_off;
    logic          lane_in;
    any_match = 1'b0;
    any_inval = 1'b0;
    match_way = '0;
    inval_way = '0;
    for (int l = sacrr_pkg::Lanes - 1; l >= 0; l--) begin
      lane_line = {row_q, l[sacrr_pkg::LaneBits-1:0]};
      lane_off  = lane_line - base_q;
      lane_in   = (lane_off & ~way_mask) == '0;
      if (lane_in && valid_q[lane_line] && (rd_tags[l] == tag_q)) begin
        any_match = 1'b1;
        match_way = lane_off;
      end
      if (lane_in && !valid_q[lane_line]) begin
        any_inval = 1'b1;
        inval_way = lane_off;
      end
    end
  end

  assign out_load  = (state_q == StFinish) && (!out_valid_q || out_ready_i);
  assign fill_we   = out_load && !hit_q;
  assign fill_way  = found_q ? way_q : (lfsr_nxt[LB-1:0] & way_mask);
  assign fill_line = base_q + fill_way;
  assign req_pop_o = (state_q == StIdle) && req_valid_i;

  always_comb begin
    state_d     = state_q;
    tag_d       = tag_q;
    base_d      = base_q;
    wlog_d      = wlog_q;
    row_d       = row_q;
    last_row_d  = last_row_q;
    hit_d       = hit_q;
    found_d     = found_q;
    way_d       = way_q;
    lfsr_d      = lfsr_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_way_d   = out_way_q;
    out_repl_d  = out_repl_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          tag_d      = req_i.tag;
          base_d     = req_i.base;
          wlog_d     = req_i.wlog;
          row_d      = req_i.base[LB-1:sacrr_pkg::LaneBits];
          last_row_d = req_i.base[LB-1:sacrr_pkg::LaneBits] + row_span;
          hit_d      = 1'b0;
          found_d    = 1'b0;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (any_match) begin
          hit_d   = 1'b1;
          way_d   = match_way;
          state_d = StFinish;
        end else begin
          if (!found_q && any_inval) begin
            found_d = 1'b1;
            way_d   = inval_way;
          end
          if (row_q == last_row_q) begin
            state_d = StFinish;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      StFinish: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          if (hit_q) begin
            hit_cnt_d  = hit_cnt_q + 1'b1;
            out_way_d  = sacrr_pkg::WayW'(way_q);
            out_repl_d = 1'b0;
          end else begin
            miss_cnt_d = miss_cnt_q + 1'b1;
            out_way_d  = sacrr_pkg::WayW'(fill_way);
            out_repl_d = !found_q;
            valid_d[fill_line] = 1'b1;
            if (!found_q) begin
              lfsr_d = lfsr_nxt;
            end
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // The user must write configuration only while idle; the block does not enforce it
    if (cfg_cmd_i.clr_valid) begin
      valid_d = '0;
    end
    if (cfg_cmd_i.seed_load) begin
      lfsr_d = (cfg_cmd_i.seed == '0) ? sacrr_pkg::SeedDefault : cfg_cmd_i.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tag_q       <= '0;
      base_q      <= '0;
      wlog_q      <= '0;
      row_q       <= '0;
      last_row_q  <= '0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      way_q       <= '0;
      lfsr_q      <= sacrr_pkg::SeedDefault;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_way_q   <= '0;
      out_repl_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      tag_q       <= tag_d;
      base_q      <= base_d;
      wlog_q      <= wlog_d;
      row_q       <= row_d;
      last_row_q  <= last_row_d;
      hit_q       <= hit_d;
      found_q     <= found_d;
      way_q       <= way_d;
      lfsr_q      <= lfsr_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
      out_way_q   <= out_way_d;
      out_repl_q  <= out_repl_d;
    end
  end

  // Tag store: one bank per lane, read the row the walk visits next
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      tag_mem[fill_line[sacrr_pkg::LaneBits-1:0]][fill_line[LB-1:sacrr_pkg::LaneBits]] <= tag_q;
    end
    for (int l = 0; l < sacrr_pkg::Lanes; l++) begin
      rd_tags[l] <= tag_mem[l][row_d];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign way_o            = out_way_q;
  assign replaced_valid_o = out_repl_q;
  assign hit_total_o      = hit_cnt_q;
  assign miss_total_o     = miss_cnt_q;

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_we && !cfg_cmd_i.clr_valid) |=> valid_q[$past(fill_line)])
    else $error("filled line not marked valid");

  a_one_count_per_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sacrr_pkg::CountW'(hit_cnt_q + miss_cnt_q) ==
                  sacrr_pkg::CountW'($past(hit_cnt_q + miss_cnt_q) + 1'b1)))
    else $error("counters not advanced by exactly one");

  a_way_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((out_way_q & ~sacrr_pkg::WayW'(way_mask)) == '0))
    else $error("result way outside the set");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (RB'(row_q - base_q[LB-1:sacrr_pkg::LaneBits]) <=
                             RB'(last_row_q - base_q[LB-1:sacrr_pkg::LaneBits])))
    else $error("walk left the set");

endmodule
`default_nettype wire

// ===== hdl/set_assoc_cache_random_replace.sv =====
// Tag store of a set-associative cache with random replacement.
// Input channel (in_valid_i / in_ready_o) takes one beat per request: a
// 32-bit byte address. Output channel (out_valid_o / out_ready_i) gives one
// beat per request: hit flag, way, eviction flag and running hit and miss
// totals, in request order.
// A front stage splits the address into set and tag and holds up to two
// requests in a queue; the back stage walks the set through a tag store of
// four lanes, one row of four tags per cycle, then fills on a miss.
// The back stage pops a new request only once it is through with the last one;
// the walk covers up to max(1, 2^W / 4) rows, 2^W the associativity, and stops
// at the first row that hits. A request is popped from the queue while idle,
// walks its rows, then loads the result register in the finish state.
// Reset clears all valid bits and both counters and loads the LFSR with the
// default seed; no clearing pass is needed. Writing ways_log2 drops every
// line; writing random_seed reloads the LFSR. While the receiver stalls the
// result beat holds, the back stage waits with its next result, and the
// queue keeps taking requests until full.
`default_nettype none
module set_assoc_cache_random_replace (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sacrr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [sacrr_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [sacrr_pkg::AddrBits-1:0]    address_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic                              hit_o,
  output      logic [sacrr_pkg::WayW-1:0]        way_o,
  output      logic                              replaced_valid_o,
  output      logic [sacrr_pkg::CountW-1:0]      hit_total_o,
  output      logic [sacrr_pkg::CountW-1:0]      miss_total_o
);

  logic [sacrr_pkg::WaysLog2W-1:0] ways_log2_q, ways_log2_d;
  sacrr_pkg::cfg_cmd_t             cfg_cmd;
  logic                            req_valid;
  sacrr_pkg::req_t                 req;
  logic                            req_pop;

  // Decode register writes; indexes past the list are dropped
  always_comb begin
    ways_log2_d       = ways_log2_q;
    cfg_cmd.clr_valid = 1'b0;
    cfg_cmd.seed_load = 1'b0;
    cfg_cmd.seed      = cfg_data_i[sacrr_pkg::SeedW-1:0];
    if (cfg_we_i) begin
      case (cfg_index_i)
        sacrr_pkg::CfgWaysLog2: begin
          ways_log2_d       = cfg_data_i[sacrr_pkg::WaysLog2W-1:0];
          cfg_cmd.clr_valid = 1'b1;
        end
        sacrr_pkg::CfgRandomSeed: begin
          cfg_cmd.seed_load = 1'b1;
        end
        default: begin
          ways_log2_d = ways_log2_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_log2_q <= '0;
    end else begin
      ways_log2_q <= ways_log2_d;
    end
  end

  // Front: classify and queue requests
  sacrr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .address_i   (address_i),
    .ways_log2_i (ways_log2_q),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  // Back: walk the set, fill on a miss, drive the result register
  sacrr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_cmd_i        (cfg_cmd),
    .req_valid_i      (req_valid),
    .req_i            (req),
    .req_pop_o        (req_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .way_o            (way_o),
    .replaced_valid_o (replaced_valid_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o)
  );

endmodule
`default_nettype wire

// ===== bench/set_assoc_cache_random_replace_tb.sv =====
`timescale 1ns / 100ps
module set_assoc_cache_random_replace_tb;

  // Geometry as the ports see it; the rest of the prediction is local.
  localparam int          LINE_BITS     = sacrr_pkg::LineBits;
  localparam int          LINES         = sacrr_pkg::LineCount;
  localparam int          OFFSET_BITS   = sacrr_pkg::OffBits;
  localparam int          BLOCK_BITS    = sacrr_pkg::TagW;
  localparam logic [15:0] SEED_FALLBACK = 16'd44257;
  localparam logic [15:0] LFSR_POLY     = 16'hB400;
  // Worst case latency is the fully associative walk; the settle wait is rounded up past it.
  localparam int          SETTLE_CYCLES = 100;

  typedef struct packed {
    logic        hit;
    logic [7:0]  way;
    logic        replaced;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_we_i    = 1'b0;
  logic [sacrr_pkg::CfgIdxW-1:0]   cfg_index_i = sacrr_pkg::CfgWaysLog2;
  logic [sacrr_pkg::CfgDataW-1:0]  cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic [sacrr_pkg::AddrBits-1:0]  address_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            hit_o;
  logic [sacrr_pkg::WayW-1:0]      way_o;
  logic                            replaced_valid_o;
  logic [sacrr_pkg::CountW-1:0]    hit_total_o;
  logic [sacrr_pkg::CountW-1:0]    miss_total_o;

  // Predicted tag store: valid bits, tags, totals, victim LFSR and geometry.
  bit                    line_valid_m [LINES];
  bit [BLOCK_BITS-1:0]   line_tag_m   [LINES];
  logic [31:0]           hit_count_m   = '0;
  logic [31:0]           miss_count_m  = '0;
  logic [15:0]           victim_lfsr_m = SEED_FALLBACK;
  logic [3:0]            ways_log2_m   = 4'd0;

  // Results still owed by the block, oldest first.
  lookup_result_t expected_lookups [$];

  int err_count      = 0;
  bit tx_gaps_on     = 1'b1;
  bit rx_stalls_on   = 1'b1;
  int rx_hold_cycles = 0;

  set_assoc_cache_random_replace dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .way_o           (way_o),
    .replaced_valid_o(replaced_valid_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o)
  );

  always #4 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Look up one address in the predicted tag store, fill on a miss and
  // return the result beat the block owes for it.
  function automatic lookup_result_t lookup_and_fill(input logic [31:0] addr);
    lookup_result_t      res;
    int                  w, sb, ways, base, pick, i, set_idx;
    logic [BLOCK_BITS-1:0] blk, tag;
    bit                  found;
    // Oversized associativity saturates at fully associative.
    w       = (ways_log2_m > LINE_BITS) ? LINE_BITS : ways_log2_m;
    sb      = LINE_BITS - w;
    ways    = 1 << w;
    blk     = addr[31:OFFSET_BITS];
    set_idx = blk & ((1 << sb) - 1);
    tag     = blk >> sb;
    base    = set_idx << w;
    res     = '0;
    pick    = 0;
    found   = 1'b0;
    // Tags are compared only behind a set valid bit.
    for (i = 0; i < ways; i++) begin
      if (!found && line_valid_m[base + i] && line_tag_m[base + i] == tag) begin
        found = 1'b1;
        pick  = i;
      end
    end
    res.hit = found;
    if (found) begin
      hit_count_m++;
    end else begin
      miss_count_m++;
      // Take the lowest empty way; only a full set draws from the LFSR.
      for (i = 0; i < ways; i++) begin
        if (!found && !line_valid_m[base + i]) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (!found) begin
        victim_lfsr_m = (victim_lfsr_m >> 1) ^ (victim_lfsr_m[0] ? LFSR_POLY : 16'h0000);
        pick          = victim_lfsr_m & (ways - 1);
        res.replaced  = 1'b1;
      end
      line_tag_m[base + pick]   = tag;
      line_valid_m[base + pick] = 1'b1;
    end
    res.way    = 8'(pick);
    res.hits   = hit_count_m;
    res.misses = miss_count_m;
    return res;
  endfunction

  // Offer one address beat; hold valid and payload until accepted, then
  // queue the predicted result. Enter and leave at a rising edge.
  task automatic send_lookup(input logic [31:0] addr);
    int idle;
    idle = tx_gaps_on ? pick_gap() : 0;
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_lookups.push_back(lookup_and_fill(addr));
  endtask

  // Drop valid and wait until every owed result beat has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_lookups.size() != 0);
  endtask

  // Write both registers on consecutive edges; call only with the block idle.
  task automatic program_cache(input logic [3:0] ways_log2, input logic [15:0] seed);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sacrr_pkg::CfgWaysLog2;
    cfg_data_i  <= {12'h000, ways_log2};
    @(posedge clk_i);
    cfg_index_i <= sacrr_pkg::CfgRandomSeed;
    cfg_data_i  <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // A geometry write drops every line; totals survive.
    ways_log2_m = ways_log2;
    foreach (line_valid_m[j]) line_valid_m[j] = 1'b0;
    // A zero seed falls back so the LFSR never locks up.
    victim_lfsr_m = (seed == 16'h0000) ? SEED_FALLBACK : seed;
  endtask

  // Reset configuration: one way, default seed. Hit, miss, eviction and
  // the address extremes.
  task automatic test_direct_mapped_lookup();
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_003F);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_4000);
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFC0);
    send_lookup(32'h8000_0000);
    send_lookup(32'h7FFF_FFFF);
    send_lookup(32'h8000_0010);
    wait_all_results();
  endtask

  // Hold the receiver off for a long stretch while beats keep coming so
  // the queue fills and in_ready_o drops.
  task automatic test_result_backpressure();
    int n;
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = 300;
    while (rx_hold_cycles != 0) @(posedge clk_i);
    for (n = 0; n < 16; n++) begin
      send_lookup(($urandom_range(0, 3) << 14) | ($urandom_range(0, 3) << 6) |
                  $urandom_range(0, 63));
    end
    wait_all_results();
    tx_gaps_on = 1'b1;
  endtask

  // Four ways, zero seed: fill one set in way order, then force a random
  // victim and hit on the newcomer.
  task automatic test_set_eviction();
    int t;
    program_cache(4'd2, 16'h0000);
    for (t = 0; t < 5; t++) begin
      send_lookup((t << 12) | (5 << 6) | t);
    end
    send_lookup((4 << 12) | (5 << 6));
    send_lookup(5 << 6);
    wait_all_results();
  endtask

  // Associativity beyond the line count behaves fully associative; a later
  // geometry write must forget what was cached.
  task automatic test_oversized_ways();
    program_cache(4'd15, 16'h0001);
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_0040);
    send_lookup(32'h0000_003F);
    send_lookup(32'hFFFF_FFFF);
    wait_all_results();
    program_cache(4'd8, 16'hFFFF);
    send_lookup(32'h0000_0000);
    wait_all_results();
  endtask

  // One configuration, then a stream of addresses drawn from a growing tag
  // pool so sets fill, hit and evict. Each tag keeps its own set. A few
  // beats are raw random addresses.
  task automatic run_traffic_phase(input logic [3:0] ways_log2, input logic [15:0] seed,
                                   input int count, input int new_eighths,
                                   input bit tx_idle, input bit rx_idle);
    int                    sb, sets_used, next_tag, k, n;
    logic [BLOCK_BITS-1:0] tag_base, tag, blk;
    logic [7:0]            set_base, set_idx;
    logic [5:0]            offset;
    logic [31:0]           addr;
    program_cache(ways_log2, seed);
    tx_gaps_on   = tx_idle;
    rx_stalls_on = rx_idle;
    sb        = LINE_BITS - ((ways_log2 > LINE_BITS) ? LINE_BITS : ways_log2);
    sets_used = (sb >= 6) ? 4 : 1;
    tag_base  = BLOCK_BITS'($urandom());
    set_base  = 8'($urandom());
    next_tag  = 0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 15) == 0) begin
        addr = $urandom();
      end else begin
        if (next_tag == 0 || $urandom_range(0, 7) < new_eighths) begin
          k = next_tag;
          next_tag++;
        end else begin
          k = $urandom_range(0, next_tag - 1);
        end
        tag     = BLOCK_BITS'(tag_base + k);
        set_idx = 8'((set_base + (k % sets_used)) & ((1 << sb) - 1));
        blk     = (tag << sb) | set_idx;
        offset  = 6'($urandom_range(0, 63));
        addr    = {blk, offset};
      end
      send_lookup(addr);
    end
    wait_all_results();
  endtask

  // Sweep associativity from direct-mapped to fully associative; keep the
  // slow fully associative runs to a minority of beats.
  task automatic test_random_traffic();
    run_traffic_phase(4'd0,  16'($urandom_range(0, 65535)), 100, 4, 1'b1, 1'b1);
    run_traffic_phase(4'd1,  16'hFFFF,                       70, 4, 1'b0, 1'b0);
    run_traffic_phase(4'd2,  16'($urandom_range(0, 65535)),  70, 4, 1'b1, 1'b0);
    run_traffic_phase(4'd3,  16'($urandom_range(0, 65535)),  70, 4, 1'b0, 1'b1);
    run_traffic_phase(4'd5,  16'($urandom_range(0, 65535)),  90, 5, 1'b1, 1'b1);
    run_traffic_phase(4'd8,  16'($urandom_range(0, 65535)), 300, 7, 1'b1, 1'b1);
    run_traffic_phase(4'd15, 16'h0000,                       50, 4, 1'b1, 1'b1);
    run_traffic_phase(4'd4,  16'h0001,                       50, 4, 1'b1, 1'b1);
  endtask

  // Receiver: ready in runs, random stalls when enabled, and one long hold
  // on request, counted here in cycles.
  initial begin : result_ready_gen
    int run;
    bit rdy;
    forever begin
      if (rx_hold_cycles != 0) begin
        run            = rx_hold_cycles;
        rx_hold_cycles = 0;
        rdy            = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        run = pick_gap() + 1;
        rdy = 1'b0;
      end else begin
        run = $urandom_range(1, 8);
        rdy = 1'b1;
      end
      out_ready_i <= rdy;
      repeat (run) @(posedge clk_i);
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    lookup_result_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_lookups.size() == 0) begin
        $error("result beat with no lookup pending");
        err_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          err_count++;
        end
        if (way_o !== want.way) begin
          $error("way: expected %0d, got %0d", want.way, way_o);
          err_count++;
        end
        if (replaced_valid_o !== want.replaced) begin
          $error("replaced_valid: expected %0d, got %0d", want.replaced, replaced_valid_o);
          err_count++;
        end
        if (hit_total_o !== want.hits) begin
          $error("hit_total: expected %0d, got %0d", want.hits, hit_total_o);
          err_count++;
        end
        if (miss_total_o !== want.misses) begin
          $error("miss_total: expected %0d, got %0d", want.misses, miss_total_o);
          err_count++;
        end
      end
    end
  end

  initial begin : test_sequence
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_direct_mapped_lookup();
    test_result_backpressure();
    test_set_eviction();
    test_oversized_ways();
    test_random_traffic();
    wait_all_results();
    // Catch any stray beat the block might still produce.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("set_assoc_cache_random_replace_tb: done, clean");
    end else begin
      $display("set_assoc_cache_random_replace_tb: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : run_limit
    #8000000;
    $display("set_assoc_cache_random_replace_tb: done, errors");
    $finish;
  end

endmodule
